/* hw/rtl/mrm_pkg.sv */
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and the Modbus CRC byte step for the RTU master framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Input operations.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Request kinds.
  localparam logic [2:0] RK_COILS      = 3'd0;
  localparam logic [2:0] RK_DISCRETE   = 3'd1;
  localparam logic [2:0] RK_HOLDING    = 3'd2;
  localparam logic [2:0] RK_INPUT_REGS = 3'd3;
  localparam logic [2:0] RK_WRITE_COIL = 3'd4;
  localparam logic [2:0] RK_WRITE_REG  = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Reply status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_HEADER    = 3'd3;
  localparam logic [2:0] ST_COUNT     = 3'd4;
  localparam logic [2:0] ST_ECHO      = 3'd5;

  localparam int FRAME_BODY = 6;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  request_kind;
    logic [15:0] address;
    logic [7:0]  quantity;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] data_value;
    logic [7:0]  data_index;
    logic [3:0]  bit_count;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // Hand-off from the reply engine to the output sequencer.
  typedef struct packed {
    logic                           frame;
    logic                           single;
    logic [FRAME_BODY-1:0][7:0]     frame_bytes;
    out_item_t                      result;
  } tx_load_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/modbus_rtu_master_framer.sv */
// Flow: an item is registered at acceptance; its result is registered again
// in the output sequencer, once that is free, and shown from there.
// Throughput: one reply byte or end item per cycle unless the output stalls; a
// start item holds the input until the single output sequencer sends 8 bytes.
// Reset: synchronous; clears the pending request, reply checks and queues,
// and sets the slave id to 1.
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer
// Modbus RTU master request builder and reply checker with an input register
// in front of the reply engine and an output sequencer behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_framer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mrm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mrm_pkg::out_item_t      out_data
);

  logic              in_full;
  mrm_pkg::in_item_t in_reg;
  logic              fire;
  logic              tx_ready;
  mrm_pkg::tx_load_t load;

  assign in_stall = in_full && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  mrm_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (in_full),
    .item       (in_reg),
    .tx_ready   (tx_ready),
    .fire       (fire),
    .load       (load)
  );

  mrm_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_en   (fire),
    .ready     (tx_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/mrm_core.sv */
// ----------------------------------------------------------------------------
// mrm_core
// Request setup and reply checking: holds the pending request, the two-byte
// reply delay line, the running CRC and the header, echo and count checks.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             item_valid,
  input  wire mrm_pkg::in_item_t item,
  input  wire logic             tx_ready,
  output logic                  fire,
  output mrm_pkg::tx_load_t     load
);

  localparam int LW = mrm_pkg::LEN_W;

  logic [7:0]    node_id;
  logic [2:0]    pending_kind, pending_kind_next;
  logic [15:0]   pending_address, pending_address_next;
  logic [7:0]    pending_quantity, pending_quantity_next;
  logic [15:0]   pending_value, pending_value_next;
  logic [LW-1:0] reply_length, reply_length_next;
  logic [7:0]    held0, held0_next, held1, held1_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [7:0]    reply_count_byte, reply_count_byte_next;
  logic          header_mismatch, header_mismatch_next;
  logic          echo_mismatch, echo_mismatch_next;
  logic [7:0]    word_high_byte, word_high_byte_next;

  logic          is_write, is_coil;
  logic [LW-1:0] p, pos;
  logic [LW+2:0] first_coil;
  logic [LW+2:0] coil_rem;
  logic [3:0]    coil_n;
  logic [7:0]    coil_mask;
  logic [LW-1:0] reg_idx;
  logic [7:0]    want;
  logic [7:0]    echo0, echo1;
  logic [8:0]    want_coil_count, want_reg_count;
  logic [2:0]    status;
  logic [15:0]   crc_upd;

  assign fire     = item_valid && tx_ready;
  assign is_write = pending_kind >= mrm_pkg::RK_WRITE_COIL;
  assign is_coil  = pending_kind <= mrm_pkg::RK_DISCRETE;
  assign p        = reply_length - LW'(2);
  assign pos      = reply_length - LW'(5);
  assign first_coil = {pos, 3'b000};
  assign coil_rem = {{(LW-5){1'b0}}, pending_quantity} - first_coil;
  assign coil_n   = (coil_rem > (LW+3)'(8)) ? 4'd8 : coil_rem[3:0];
  assign coil_mask = 8'hFF >> (4'd8 - coil_n);
  assign reg_idx  = {1'b0, pos[LW-1:1]};
  assign crc_upd  = mrm_pkg::crc_step(running_crc, held0);
  assign echo0    = (pending_kind == mrm_pkg::RK_WRITE_COIL) ?
                    ((pending_value != 16'h0000) ? 8'hFF : 8'h00) : pending_value[15:8];
  assign echo1    = (pending_kind == mrm_pkg::RK_WRITE_COIL) ? 8'h00 : pending_value[7:0];
  assign want_coil_count = ({1'b0, pending_quantity} + 9'd7) >> 3;
  assign want_reg_count  = {pending_quantity, 1'b0};

  always_comb begin
    priority if (p == LW'(2)) begin
      want = pending_address[15:8];
    end else if (p == LW'(3)) begin
      want = pending_address[7:0];
    end else if (p == LW'(4)) begin
      want = echo0;
    end else begin
      want = echo1;
    end
  end

  // Status in the order the checks are defined.
  always_comb begin
    priority if (reply_length < LW'(5)) begin
      status = mrm_pkg::ST_SHORT;
    end else if (held0 != running_crc[15:8] || held1 != running_crc[7:0]) begin
      status = mrm_pkg::ST_CRC;
    end else if (header_mismatch) begin
      status = mrm_pkg::ST_HEADER;
    end else if (is_coil) begin
      status = ({1'b0, reply_count_byte} != want_coil_count) ? mrm_pkg::ST_COUNT
                                                             : mrm_pkg::ST_OK;
    end else if (!is_write) begin
      status = ({1'b0, reply_count_byte} != want_reg_count) ? mrm_pkg::ST_COUNT
                                                            : mrm_pkg::ST_OK;
    end else begin
      status = (echo_mismatch || reply_length < LW'(8)) ? mrm_pkg::ST_ECHO
                                                        : mrm_pkg::ST_OK;
    end
  end

  always_comb begin
    pending_kind_next     = pending_kind;
    pending_address_next  = pending_address;
    pending_quantity_next = pending_quantity;
    pending_value_next    = pending_value;
    reply_length_next     = reply_length;
    held0_next            = held0;
    held1_next            = held1;
    running_crc_next      = running_crc;
    reply_count_byte_next = reply_count_byte;
    header_mismatch_next  = header_mismatch;
    echo_mismatch_next    = echo_mismatch;
    word_high_byte_next   = word_high_byte;
    load                  = '0;

    unique case (item.op)
      mrm_pkg::OP_START: begin
        if (item.request_kind <= mrm_pkg::RK_WRITE_REG) begin
          pending_kind_next     = item.request_kind;
          pending_address_next  = item.address;
          pending_quantity_next = item.quantity;
          pending_value_next    = item.write_value;
          reply_length_next     = '0;
          held0_next            = '0;
          held1_next            = '0;
          running_crc_next      = mrm_pkg::CRC_INIT;
          reply_count_byte_next = '0;
          header_mismatch_next  = 1'b0;
          echo_mismatch_next    = 1'b0;
          word_high_byte_next   = '0;
          load.frame            = 1'b1;
          load.frame_bytes[0]   = node_id;
          load.frame_bytes[1]   = {5'b0, item.request_kind} + 8'd1;
          load.frame_bytes[2]   = item.address[15:8];
          load.frame_bytes[3]   = item.address[7:0];
          if (item.request_kind <= mrm_pkg::RK_INPUT_REGS) begin
            load.frame_bytes[4] = 8'h00;
            load.frame_bytes[5] = item.quantity;
          end else if (item.request_kind == mrm_pkg::RK_WRITE_COIL) begin
            load.frame_bytes[4] = (item.write_value != 16'h0000) ? 8'hFF : 8'h00;
            load.frame_bytes[5] = 8'h00;
          end else begin
            load.frame_bytes[4] = item.write_value[15:8];
            load.frame_bytes[5] = item.write_value[7:0];
          end
        end
      end
      mrm_pkg::OP_BYTE: begin
        if (reply_length < LW'(mrm_pkg::MAX_FRAME_BYTES)) begin
          // The oldest held byte is now known to be payload, not CRC.
          if (reply_length >= LW'(2)) begin
            running_crc_next = crc_upd;
            priority if (p == LW'(0)) begin
              if (held0 != node_id) header_mismatch_next = 1'b1;
            end else if (p == LW'(1)) begin
              if (held0 != ({5'b0, pending_kind} + 8'd1)) header_mismatch_next = 1'b1;
            end else if (is_write) begin
              if (p <= LW'(5) && held0 != want) echo_mismatch_next = 1'b1;
            end else if (p == LW'(2)) begin
              reply_count_byte_next = held0;
            end else if (is_coil) begin
              if (first_coil < {{(LW-5){1'b0}}, pending_quantity}) begin
                load.single            = 1'b1;
                load.result.kind       = mrm_pkg::KIND_DATA;
                load.result.data_value = {8'h00, held0 & coil_mask};
                load.result.data_index = first_coil[7:0];
                load.result.bit_count  = coil_n;
              end
            end else if (!pos[0]) begin
              word_high_byte_next = held0;
            end else begin
              if (reg_idx < LW'(pending_quantity)) begin
                load.single            = 1'b1;
                load.result.kind       = mrm_pkg::KIND_DATA;
                load.result.data_value = {word_high_byte, held0};
                load.result.data_index = reg_idx[7:0];
              end
            end
          end
          held0_next        = held1;
          held1_next        = item.rx_byte;
          reply_length_next = reply_length + LW'(1);
        end
      end
      mrm_pkg::OP_END: begin
        load.single           = 1'b1;
        load.result.kind      = mrm_pkg::KIND_STATUS;
        load.result.status    = status;
        load.result.last      = 1'b1;
        reply_length_next     = '0;
        held0_next            = '0;
        held1_next            = '0;
        running_crc_next      = mrm_pkg::CRC_INIT;
        reply_count_byte_next = '0;
        header_mismatch_next  = 1'b0;
        echo_mismatch_next    = 1'b0;
        word_high_byte_next   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 8'h01;
    end else if (cfg_we) begin
      node_id <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_kind     <= '0;
      pending_address  <= '0;
      pending_quantity <= '0;
      pending_value    <= '0;
      reply_length     <= '0;
      held0            <= '0;
      held1            <= '0;
      running_crc      <= mrm_pkg::CRC_INIT;
      reply_count_byte <= '0;
      header_mismatch  <= 1'b0;
      echo_mismatch    <= 1'b0;
      word_high_byte   <= '0;
    end else if (fire) begin
      pending_kind     <= pending_kind_next;
      pending_address  <= pending_address_next;
      pending_quantity <= pending_quantity_next;
      pending_value    <= pending_value_next;
      reply_length     <= reply_length_next;
      held0            <= held0_next;
      held1            <= held1_next;
      running_crc      <= running_crc_next;
      reply_count_byte <= reply_count_byte_next;
      header_mismatch  <= header_mismatch_next;
      echo_mismatch    <= echo_mismatch_next;
      word_high_byte   <= word_high_byte_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrm_tx.sv */
// ----------------------------------------------------------------------------
// mrm_tx
// Output sequencer: plays out an 8-byte request with its CRC computed one
// byte per beat, or presents a single data or status result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_tx (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mrm_pkg::tx_load_t load,
  input  wire logic              load_en,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mrm_pkg::out_item_t     out_data
);

  logic                                 active;
  logic                                 is_frame;
  logic [2:0]                           idx;
  logic [mrm_pkg::FRAME_BODY-1:0][7:0]  frame_bytes;
  logic [15:0]                          crc;
  mrm_pkg::out_item_t                   res;
  logic [7:0]                           cur_byte;
  logic                                 accept, final_beat;

  assign accept     = active && !out_stall;
  assign final_beat = !is_frame || idx == 3'd7;
  assign ready      = !active || (accept && final_beat);
  assign out_valid  = active;

  always_comb begin
    unique case (idx)
      3'd0: cur_byte = frame_bytes[0];
      3'd1: cur_byte = frame_bytes[1];
      3'd2: cur_byte = frame_bytes[2];
      3'd3: cur_byte = frame_bytes[3];
      3'd4: cur_byte = frame_bytes[4];
      3'd5: cur_byte = frame_bytes[5];
      3'd6: cur_byte = crc[15:8];
      3'd7: cur_byte = crc[7:0];
    endcase
  end

  always_comb begin
    if (is_frame) begin
      out_data         = '0;
      out_data.kind    = mrm_pkg::KIND_TX;
      out_data.tx_byte = cur_byte;
      out_data.last    = idx == 3'd7;
    end else begin
      out_data = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      is_frame <= 1'b0;
      idx      <= '0;
    end else if (load_en && (load.frame || load.single)) begin
      active   <= 1'b1;
      is_frame <= load.frame;
      idx      <= '0;
    end else if (accept) begin
      if (final_beat) active <= 1'b0;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && (load.frame || load.single)) begin
      frame_bytes <= load.frame_bytes;
      res         <= load.result;
      crc         <= mrm_pkg::CRC_INIT;
    end else if (accept && is_frame && idx < 3'd6) begin
      crc <= mrm_pkg::crc_step(crc, cur_byte);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrm_checker.sv */
// ----------------------------------------------------------------------------
// mrm_checker
// Port-level checks on the framer's output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mrm_pkg::out_item_t out_data
);

  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // A request goes out as an unbroken run of transmit beats.
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.kind == mrm_pkg::KIND_TX && !out_data.last
    |=> out_valid && out_data.kind == mrm_pkg::KIND_TX)
    else $error("request frame interrupted");

  // Status beats always close a reply; data beats never do.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kind == mrm_pkg::KIND_STATUS) == out_data.last ||
                  out_data.kind == mrm_pkg::KIND_TX)
    else $error("last flag does not match result kind");

  // Coil data carries at most one byte of bits; register words carry none.
  a_bit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == mrm_pkg::KIND_DATA |->
      out_data.bit_count <= 4'd8 &&
      (out_data.bit_count == 4'd0 || out_data.data_value[15:8] == 8'h00))
    else $error("bad coil bit count");

endmodule

bind modbus_rtu_master_framer mrm_checker u_mrm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
